// ----- design/graph_adjacency_engine_unit_assert.svh -----
// Assertion macros for the graph adjacency engine.
// Used by the top level only; expands to nothing when SYNTHESIS is defined.
`ifndef GRAPH_ADJACENCY_ENGINE_UNIT_ASSERT_SVH
`define GRAPH_ADJACENCY_ENGINE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Property holds on every clock edge outside reset.
`define GAE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("gae assertion failed");
// Consequent holds in the cycle after the antecedent.
`define GAE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gae sequencing assertion failed");
`else
`define GAE_ASSERT(lbl, clk, rst_n, prop)
`define GAE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/gae_pkg.sv -----
// Shared types and constants for the graph adjacency engine.
// No dependencies; imported by the controller, datapath, top level, checker and testbench.
package gae_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int OP_W  = 3;
  localparam int VTX_W = 4;
  localparam int VAL_W = 5;
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] VC_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT    = 3'd0,
    OP_REMOVE    = 3'd1,
    OP_CONNECTED = 3'd2,
    OP_DEGREE    = 3'd3,
    OP_POPULAR   = 3'd4,
    OP_PATH      = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_RD_A,
    S_WR_A,
    S_RD_B,
    S_WR_B,
    S_CHK,
    S_DEG,
    S_POP_RD,
    S_POP_CMP,
    S_PATH_PICK,
    S_PATH_EXP,
    S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    RS_A,
    RS_B,
    RS_IDX,
    RS_PICK
  } rd_sel_t;

  typedef enum logic [2:0] {
    VS_ZERO,
    VS_ONE,
    VS_CONN,
    VS_DEG,
    VS_BEST
  } val_sel_t;

  typedef struct packed {
    logic     load;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_en;
    logic     wr_to_b;
    logic     pop_clear;
    logic     pop_cmp;
    logic     path_init;
    logic     path_pick;
    logic     path_exp;
    logic     set_val;
    val_sel_t val_sel;
    logic     push;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            err;
    logic            same_ab;
    logic            cnt_zero;
    logic            scan_last;
    logic            pend_none;
    logic            found;
    logic            out_free;
  } sts_t;

endpackage

// ----- design/gae_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gae_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/gae_ctrl.sv -----
// Sequencing state machine for the graph adjacency engine.
// Depends on gae_pkg; drives the datapath through cmd_t, reads sts_t.
module gae_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  gae_pkg::sts_t sts,
  output gae_pkg::cmd_t cmd
);
  import gae_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        priority if (sts.err) begin
          state_nxt = S_RESULT;
        end else begin
          unique case (sts.op)
            OP_INSERT, OP_REMOVE, OP_CONNECTED, OP_DEGREE: state_nxt = S_RD_A;
            OP_POPULAR: state_nxt = sts.cnt_zero ? S_RESULT : S_POP_RD;
            OP_PATH:    state_nxt = sts.same_ab ? S_RESULT : S_PATH_PICK;
            default:    state_nxt = S_RESULT;
          endcase
        end
      end
      S_RD_A: begin
        unique case (sts.op)
          OP_INSERT, OP_REMOVE: state_nxt = S_WR_A;
          OP_CONNECTED:         state_nxt = S_CHK;
          default:              state_nxt = S_DEG;
        endcase
      end
      S_WR_A:      state_nxt = S_RD_B;
      S_RD_B:      state_nxt = S_WR_B;
      S_WR_B:      state_nxt = S_RESULT;
      S_CHK:       state_nxt = S_RESULT;
      S_DEG:       state_nxt = S_RESULT;
      S_POP_RD:    state_nxt = S_POP_CMP;
      S_POP_CMP:   state_nxt = sts.scan_last ? S_RESULT : S_POP_RD;
      S_PATH_PICK: state_nxt = sts.pend_none ? S_RESULT : S_PATH_EXP;
      S_PATH_EXP:  state_nxt = sts.found ? S_RESULT : S_PATH_PICK;
      S_RESULT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
      end
      S_DISPATCH: begin
        priority if (sts.err) begin
          cmd.set_val = 1'b1;
          cmd.val_sel = VS_ZERO;
        end else begin
          unique case (sts.op)
            OP_INSERT, OP_REMOVE, OP_CONNECTED, OP_DEGREE: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RS_A;
            end
            OP_POPULAR: begin
              cmd.pop_clear = 1'b1;
              cmd.set_val   = sts.cnt_zero;
              cmd.val_sel   = VS_ZERO;
            end
            OP_PATH: begin
              cmd.path_init = 1'b1;
              cmd.set_val   = sts.same_ab;
              cmd.val_sel   = VS_ONE;
            end
            default: begin
              cmd.set_val = 1'b1;
              cmd.val_sel = VS_ZERO;
            end
          endcase
        end
      end
      S_WR_A: begin
        cmd.wr_en  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RS_B;
      end
      S_WR_B: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_to_b = 1'b1;
        cmd.set_val = 1'b1;
        cmd.val_sel = VS_ZERO;
      end
      S_CHK: begin
        cmd.set_val = 1'b1;
        cmd.val_sel = VS_CONN;
      end
      S_DEG: begin
        cmd.set_val = 1'b1;
        cmd.val_sel = VS_DEG;
      end
      S_POP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RS_IDX;
      end
      S_POP_CMP: begin
        cmd.pop_cmp = 1'b1;
        cmd.set_val = sts.scan_last;
        cmd.val_sel = VS_BEST;
      end
      S_PATH_PICK: begin
        cmd.rd_en     = !sts.pend_none;
        cmd.rd_sel    = RS_PICK;
        cmd.path_pick = !sts.pend_none;
        cmd.set_val   = sts.pend_none;
        cmd.val_sel   = VS_ZERO;
      end
      S_PATH_EXP: begin
        cmd.path_exp = 1'b1;
        cmd.set_val  = sts.found;
        cmd.val_sel  = VS_ONE;
      end
      S_RESULT: begin
        cmd.push = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- design/gae_datapath.sv -----
// Datapath of the graph adjacency engine: item registers, adjacency RAM,
// scan and search registers, result and output registers. Uses gae_pkg, gae_ram.
module gae_datapath #(
  parameter int MAX_VERTICES = gae_pkg::MAX_VERTICES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [gae_pkg::OP_W-1:0]   in_operation,
  input  logic [gae_pkg::VTX_W-1:0]  in_vertex_a,
  input  logic [gae_pkg::VTX_W-1:0]  in_vertex_b,
  input  logic                       cfg_we,
  input  logic [gae_pkg::CNT_W-1:0]  cfg_data,
  input  gae_pkg::cmd_t              cmd,
  output gae_pkg::sts_t              sts,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [gae_pkg::VAL_W-1:0]  out_value,
  output logic                       out_error
);
  import gae_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int DW = $clog2(MAX_VERTICES + 1);
  localparam int KW = (DW > CNT_W) ? DW : CNT_W;

  typedef logic [MAX_VERTICES-1:0] row_t;

  function automatic row_t vtx_oh(input logic [VTX_W-1:0] v);
    row_t r;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      r[i] = (i == int'(v));
    end
    return r;
  endfunction

  function automatic logic [DW-1:0] popcnt(input row_t x);
    logic [DW-1:0] n;
    n = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      n = n + DW'(x[i]);
    end
    return n;
  endfunction

  logic [OP_W-1:0]  op_r;
  logic [VTX_W-1:0] va_r, vb_r;
  logic [CNT_W-1:0] vc_r;
  logic [KW-1:0]    idx_r;
  logic [VAL_W-1:0] best_r, best_nxt;
  logic [DW-1:0]    best_deg_r, best_deg_nxt;
  row_t             visited_r, done_r, row_vld_r;
  logic             rd_vld_r;
  logic [VAL_W-1:0] res_val_r, res_val_nxt;
  logic             res_err_r;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_value_r;
  logic             out_error_r;

  logic [KW-1:0]    act_cnt;
  row_t             act_mask, row, row_act, pend, pick_oh, wr_oh, wr_data, rd_data;
  logic [AW-1:0]    rd_addr, wr_addr, pick_idx;
  logic [DW-1:0]    deg;
  logic             a_ok, b_ok, err_w;

  // Count in use saturates at the matrix size.
  assign act_cnt = (KW'(vc_r) > KW'(MAX_VERTICES)) ? KW'(MAX_VERTICES) : KW'(vc_r);

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      act_mask[i] = (KW'(i) < act_cnt);
    end
  end

  assign a_ok = (KW'(va_r) < act_cnt);
  assign b_ok = (KW'(vb_r) < act_cnt);

  always_comb begin
    unique case (op_r)
      OP_INSERT, OP_REMOVE, OP_CONNECTED, OP_PATH: err_w = !(a_ok && b_ok);
      OP_DEGREE: err_w = !a_ok;
      default:   err_w = 1'b0;
    endcase
  end

  // Rows never written read as empty.
  assign row     = rd_vld_r ? rd_data : '0;
  assign row_act = row & act_mask;
  assign deg     = popcnt(row_act);

  assign pend    = visited_r & ~done_r;
  assign pick_oh = pend & (~pend + row_t'(1));

  always_comb begin
    pick_idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (pend[i]) pick_idx = AW'(i);
    end
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RS_A:    rd_addr = AW'(va_r);
      RS_B:    rd_addr = AW'(vb_r);
      RS_IDX:  rd_addr = AW'(idx_r);
      RS_PICK: rd_addr = pick_idx;
      default: rd_addr = '0;
    endcase
  end

  assign wr_addr = cmd.wr_to_b ? AW'(vb_r) : AW'(va_r);
  assign wr_oh   = cmd.wr_to_b ? vtx_oh(va_r) : vtx_oh(vb_r);
  assign wr_data = (op_r == OP_INSERT) ? (row | wr_oh) : (row & ~wr_oh);

  gae_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_rows (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Keep the first lowest-index row with the greatest degree.
  always_comb begin
    best_nxt     = best_r;
    best_deg_nxt = best_deg_r;
    if (deg > best_deg_r) begin
      best_nxt     = VAL_W'(idx_r);
      best_deg_nxt = deg;
    end
  end

  always_comb begin
    unique case (cmd.val_sel)
      VS_ZERO: res_val_nxt = '0;
      VS_ONE:  res_val_nxt = VAL_W'(1);
      VS_CONN: res_val_nxt = VAL_W'(|(row & vtx_oh(vb_r)));
      VS_DEG:  res_val_nxt = VAL_W'(deg);
      VS_BEST: res_val_nxt = best_nxt;
      default: res_val_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r        <= VC_RESET;
      row_vld_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) vc_r <= cfg_data;
      if (cmd.wr_en) row_vld_r[wr_addr] <= 1'b1;
      if (cmd.rd_en) rd_vld_r <= row_vld_r[rd_addr];
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_operation;
      va_r <= in_vertex_a;
      vb_r <= in_vertex_b;
    end
    if (cmd.pop_clear) begin
      idx_r      <= '0;
      best_r     <= '0;
      best_deg_r <= '0;
    end else if (cmd.pop_cmp) begin
      idx_r      <= idx_r + KW'(1);
      best_r     <= best_nxt;
      best_deg_r <= best_deg_nxt;
    end
    if (cmd.path_init) begin
      visited_r <= vtx_oh(va_r);
      done_r    <= '0;
    end else begin
      if (cmd.path_pick) done_r <= done_r | pick_oh;
      if (cmd.path_exp) visited_r <= visited_r | row_act;
    end
    if (cmd.set_val) begin
      res_val_r <= res_val_nxt;
      res_err_r <= err_w;
    end
    if (cmd.push) begin
      out_value_r <= res_val_r;
      out_error_r <= res_err_r;
    end
  end

  assign sts.op        = op_r;
  assign sts.err       = err_w;
  assign sts.same_ab   = (va_r == vb_r);
  assign sts.cnt_zero  = (act_cnt == '0);
  assign sts.scan_last = ((idx_r + KW'(1)) >= act_cnt);
  assign sts.pend_none = (pend == '0);
  assign sts.found     = |(row_act & vtx_oh(vb_r));
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_error = out_error_r;

endmodule

// ----- design/graph_adjacency_engine_unit.sv -----
// Graph adjacency engine: controller plus datapath over a row RAM, one word at a time.
// Per word: insert/remove read and write row a, then row b; connected/degree read row a;
// errors, unused codes and empty most popular go straight to the result; most popular
// scans each row in use; path expands pending vertices until b is found or none remain.
// The next word is taken once the result is registered, later under out_stall.
// Reset (rst_n low, synchronous): graph empty through row valid bits, vertex_count 16.
`include "graph_adjacency_engine_unit_assert.svh"
module graph_adjacency_engine_unit #(
  parameter int MAX_VERTICES = gae_pkg::MAX_VERTICES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [gae_pkg::OP_W-1:0]   in_operation,
  input  logic [gae_pkg::VTX_W-1:0]  in_vertex_a,
  input  logic [gae_pkg::VTX_W-1:0]  in_vertex_b,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [gae_pkg::VAL_W-1:0]  out_value,
  output logic                       out_error,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [gae_pkg::CNT_W-1:0]  cfg_data
);
  import gae_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  // Writes must arrive only while idle (the block does not enforce it), so always take them.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  gae_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gae_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_operation (in_operation),
    .in_vertex_a  (in_vertex_a),
    .in_vertex_b  (in_vertex_b),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_error    (out_error)
  );

  `GAE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `GAE_ASSERT(a_push_needs_room, clk, rst_n, !cmd.push || !out_valid || !out_stall)
  `GAE_ASSERT(a_error_value_zero, clk, rst_n, !(out_valid && out_error) || out_value == '0)
  `GAE_ASSERT(a_write_only_busy, clk, rst_n, !cmd.wr_en || in_stall)

endmodule

// ----- sim/graph_adjacency_engine_checker.sv -----
// Result checker for graph_adjacency_engine_unit: tracks the adjacency matrix and vertex count,
// predicts one answer per accepted input word and compares every accepted result word.
// Depends on gae_pkg for field widths and operation codes.
module graph_adjacency_engine_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [gae_pkg::OP_W-1:0]   in_operation,
  input  logic [gae_pkg::VTX_W-1:0]  in_vertex_a,
  input  logic [gae_pkg::VTX_W-1:0]  in_vertex_b,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [gae_pkg::VAL_W-1:0]  out_value,
  input  logic                       out_error,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [gae_pkg::CNT_W-1:0]  cfg_data,
  output int                         fail_count,
  output int                         pending
);
  import gae_pkg::*;

  localparam int NV = MAX_VERTICES_DEF;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             error;
  } graph_answer_t;

  logic [NV-1:0]    adjacency [NV];
  logic [CNT_W-1:0] vertex_count;
  graph_answer_t    expected_answers [$];
  graph_answer_t    due;

  function automatic int live_vertices();
    return (vertex_count > NV) ? NV : int'(vertex_count);
  endfunction

  function automatic logic [NV-1:0] live_mask(input int c);
    logic [NV-1:0] m;
    m = '0;
    for (int v = 0; v < c; v++) m[v] = 1'b1;
    return m;
  endfunction

  function automatic int row_degree(input int v, input logic [NV-1:0] act);
    logic [NV-1:0] row;
    int n;
    row = adjacency[v] & act;
    n = 0;
    for (int w = 0; w < NV; w++) n += row[w];
    return n;
  endfunction

  // Closure over active vertices; a vertex always reaches itself.
  function automatic logic reaches(input int src, input int dst, input int c,
                                   input logic [NV-1:0] act);
    logic [NV-1:0] seen;
    if (src == dst) return 1'b1;
    seen = '0;
    seen[src] = 1'b1;
    repeat (NV) begin
      for (int v = 0; v < c; v++) if (seen[v]) seen = seen | (adjacency[v] & act);
    end
    return seen[dst];
  endfunction

  // Apply one word to the tracked graph and return the answer it must produce.
  function automatic graph_answer_t graph_answer(input logic [OP_W-1:0] op,
                                                 input logic [VTX_W-1:0] a,
                                                 input logic [VTX_W-1:0] b);
    int c;
    logic [NV-1:0] act;
    logic a_ok, b_ok;
    int best, best_deg, d;
    graph_answer_t ans;
    c = live_vertices();
    act = live_mask(c);
    a_ok = int'(a) < c;
    b_ok = int'(b) < c;
    ans = '0;
    case (op)
      OP_INSERT, OP_REMOVE: begin
        if (!(a_ok && b_ok)) begin
          ans.error = 1'b1;
        end else begin
          adjacency[a][b] = (op == OP_INSERT);
          adjacency[b][a] = (op == OP_INSERT);
        end
      end
      OP_CONNECTED: begin
        if (!(a_ok && b_ok)) ans.error = 1'b1;
        else ans.value = {{(VAL_W-1){1'b0}}, adjacency[a][b]};
      end
      OP_DEGREE: begin
        if (!a_ok) begin
          ans.error = 1'b1;
        end else begin
          d = row_degree(a, act);
          ans.value = d[VAL_W-1:0];
        end
      end
      OP_POPULAR: begin
        best = 0;
        best_deg = 0;
        for (int i = 0; i < c; i++) begin
          d = row_degree(i, act);
          if (d > best_deg) begin
            best_deg = d;
            best = i;
          end
        end
        ans.value = best[VAL_W-1:0];
      end
      OP_PATH: begin
        if (!(a_ok && b_ok)) ans.error = 1'b1;
        else ans.value = {{(VAL_W-1){1'b0}}, reaches(a, b, c, act)};
      end
      default: ;
    endcase
    return ans;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < NV; v++) adjacency[v] = '0;
      vertex_count = VC_RESET;
      expected_answers.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) vertex_count = cfg_data;
      if (in_valid && !in_stall)
        expected_answers.push_back(graph_answer(in_operation, in_vertex_a, in_vertex_b));
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          $error("unexpected result word: value %0d error %0d", out_value, out_error);
          fail_count++;
        end else begin
          due = expected_answers.pop_front();
          if (out_value !== due.value) begin
            $error("value mismatch: expected %0d, actual %0d", due.value, out_value);
            fail_count++;
          end
          if (out_error !== due.error) begin
            $error("error mismatch: expected %0d, actual %0d", due.error, out_error);
            fail_count++;
          end
        end
      end
    end
    pending = expected_answers.size();
  end

endmodule

// ----- sim/graph_adjacency_engine_unit_tb.sv -----
// Testbench top for graph_adjacency_engine_unit: drives input, result and count channels with
// random input gaps and result stalls; graph_adjacency_engine_checker does the predicting
// and comparing. Depends on gae_pkg and the checker module.
module graph_adjacency_engine_unit_tb;
  import gae_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
  localparam int PHASE_WORDS = 136;
  localparam int SETTLE_CYCLES = 40;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [OP_W-1:0]   in_operation;
  logic [VTX_W-1:0]  in_vertex_a;
  logic [VTX_W-1:0]  in_vertex_b;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [VAL_W-1:0]  out_value;
  logic              out_error;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data;
  int                fail_count;
  int                pending;
  bit                steady = 1'b0;

  always #5 clk = ~clk;

  graph_adjacency_engine_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_operation(in_operation),
    .in_vertex_a (in_vertex_a),
    .in_vertex_b (in_vertex_b),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_value   (out_value),
    .out_error   (out_error),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  graph_adjacency_engine_checker answer_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_operation(in_operation),
    .in_vertex_a (in_vertex_a),
    .in_vertex_b (in_vertex_b),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_value   (out_value),
    .out_error   (out_error),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always @(negedge clk) begin
    out_stall <= steady ? 1'b0 : ($urandom_range(99) < 13);
  end

  task automatic send_word(input logic [OP_W-1:0] op, input logic [VTX_W-1:0] a,
                           input logic [VTX_W-1:0] b);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_vertex_a  <= a;
    in_vertex_b  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and hold until every expected word has come back.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_vertex_count(input logic [CNT_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VTX_W-1:0] pick_vertex(input int c);
    logic [31:0] r;
    if (c > 0 && $urandom_range(99) < 85) r = $urandom_range(c - 1, 0);
    else r = $urandom_range(15, 0);
    return r[VTX_W-1:0];
  endfunction

  task automatic run_random_phase(input logic [CNT_W-1:0] count, input bit dense);
    int c, roll, ins_w;
    logic [OP_W-1:0] op;
    c = (count > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(count);
    ins_w = dense ? 30 : 15;
    for (int k = 0; k < PHASE_WORDS; k++) begin
      roll = $urandom_range(99);
      if (roll < ins_w) op = OP_INSERT;
      else if (roll < 45) op = OP_REMOVE;
      else if (roll < 57) op = OP_CONNECTED;
      else if (roll < 70) op = OP_DEGREE;
      else if (roll < 80) op = OP_POPULAR;
      else if (roll < 95) op = OP_PATH;
      else if (roll < 97) op = OP_SPARE_6;
      else op = OP_SPARE_7;
      // pause mid-phase until the engine has drained
      if (k == PHASE_WORDS / 2) settle();
      send_word(op, pick_vertex(c), pick_vertex(c));
    end
  endtask

  initial begin
    logic [CNT_W-1:0] counts [9];
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = '0;
    in_vertex_a  = '0;
    in_vertex_b  = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty graph, full count from reset
    send_word(OP_POPULAR, 4'd0, 4'd0);
    send_word(OP_PATH, 4'd3, 4'd3);
    // star around vertex 0 with a self loop: degree reaches sixteen
    for (int b = 0; b < 16; b++) send_word(OP_INSERT, 4'd0, b[VTX_W-1:0]);
    send_word(OP_DEGREE, 4'd0, 4'd9);
    send_word(OP_POPULAR, 4'd7, 4'd7);
    send_word(OP_CONNECTED, 4'd0, 4'd15);
    send_word(OP_PATH, 4'd15, 4'd7);
    send_word(OP_REMOVE, 4'd0, 4'd0);
    send_word(OP_DEGREE, 4'd0, 4'd0);
    send_word(OP_REMOVE, 4'd0, 4'd15);
    send_word(OP_PATH, 4'd15, 4'd3);
    send_word(OP_SPARE_6, 4'd15, 4'd15);
    send_word(OP_SPARE_7, 4'd0, 4'd15);
    settle();

    counts[0] = 5'd31;
    counts[1] = 5'd0;
    counts[2] = 5'd1;
    counts[3] = 5'd2;
    counts[4] = CNT_W'($urandom_range(15, 3));
    counts[5] = 5'd16;
    counts[6] = CNT_W'($urandom_range(30, 17));
    counts[7] = 5'd9;
    counts[8] = 5'd16;
    for (int p = 0; p < 9; p++) begin
      write_vertex_count(counts[p]);
      steady = (p == 5);
      run_random_phase(counts[p], p[0]);
      settle();
    end
    steady = 1'b0;

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule
